[design/svm_pkg.sv]
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the sample voice mixer
// Request and result codes, payload structs, engine state type.
// ----------------------------------------------------------------------------
`default_nettype none
package svm_pkg;

   localparam int VOICES_DEF       = 8;
   localparam int SAMPLE_WORDS_DEF = 16384;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_PLAY  = 2'd1,
      REQ_STOP  = 2'd2,
      REQ_MIX   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      KIND_MIX      = 3'd0,
      KIND_STARTED  = 3'd1,
      KIND_NOFREE   = 3'd2,
      KIND_REPEATED = 3'd3,
      KIND_FINISHED = 3'd4,
      KIND_STOPPED  = 3'd5,
      KIND_WRITTEN  = 3'd6
   } kind_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [13:0]        store_addr;
      logic signed [15:0] store_value;
      logic [13:0]        sound_start;
      logic [14:0]        sound_length;
      logic               repeat_flag;
      logic [15:0]        volume;
      logic               notify_flag;
      logic [2:0]         voice_index;
   } req_type_type;

   typedef struct packed {
      logic [2:0]         result_kind;
      logic [2:0]         voice_id;
      logic signed [15:0] mixed_sample;
      logic               last_of_run;
   } rsp_type_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX_RD,
      ST_MIX_ACC,
      ST_DONE
   } back_state_type;

endpackage
`default_nettype wire

[design/svm_if.sv]
// ----------------------------------------------------------------------------
// svm_if: valid/ready channel
// Carries one item of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none
interface svm_if #(parameter type PAYLOAD_TYPE = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/svm_front.sv]
// ----------------------------------------------------------------------------
// svm_front: request intake
// Accepts request items into a short queue that feeds the voice engine.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire svm_pkg::req_type_type in_item,
   output      logic                  q_valid,
   input  wire logic                  q_take,
   output      svm_pkg::req_type_type q_item
);
   import svm_pkg::*;

   req_type_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_take && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule
`default_nettype wire

[design/svm_back.sv]
// ----------------------------------------------------------------------------
// svm_back: voice engine
// Owns voice state and sample store, executes requests, emits results.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_back #(
   parameter int VOICES       = svm_pkg::VOICES_DEF,
   parameter int SAMPLE_WORDS = svm_pkg::SAMPLE_WORDS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   output      logic                  q_take,
   input  wire svm_pkg::req_type_type q_item,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      svm_pkg::rsp_type_type out_item
);
   import svm_pkg::*;

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int AW = $clog2(SAMPLE_WORDS);

   logic [VOICES-1:0]  active_ff, active_in, repeat_ff, notify_ff;
   logic [15:0]        gain_ff [VOICES];
   logic [13:0]        base_ff [VOICES];
   logic [14:0]        span_ff [VOICES];
   logic [14:0]        pos_ff  [VOICES];
   logic signed [15:0] store_mem [SAMPLE_WORDS];
   logic signed [15:0] rd_data_ff;

   back_state_type state_ff, state_in;
   logic [VW:0]    vcnt_ff, vcnt_in;
   logic [VW-1:0]  vi;
   logic signed [34:0] acc_ff, acc_in;
   logic           use_ff, use_in;  // voice in read stage contributes
   logic           out_valid_ff, out_valid_in;
   rsp_type_type   out_ff, out_in;
   logic           pos_clr, pos_inc, play_do;
   logic [VW-1:0]  free_idx;
   logic           free_any;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [14:0]    rd_pos;
   logic           wr_do;
   logic [VW-1:0]  stop_idx;
   logic signed [32:0] prod;
   logic signed [35:0] rnd;
   logic signed [21:0] q;
   logic signed [15:0] sat;
   logic           out_free;

   assign vi       = vcnt_ff[VW-1:0];
   assign out_free = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;
   assign stop_idx  = q_item.voice_index[VW-1:0];

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_any = 1'b1;
            free_idx = VW'(i);
         end
      end
   end

   assign prod = $signed(rd_data_ff) * $signed({1'b0, gain_ff[vi]});
   assign rnd  = 36'(acc_ff) + 36'sd8192;
   assign q    = 22'(rnd >>> 14);
   assign sat  = (q > 22'sd32767) ? 16'sd32767 :
                 (q < -22'sd32768) ? -16'sd32768 : 16'(q);

   always_comb begin
      state_in     = state_ff;
      vcnt_in      = vcnt_ff;
      acc_in       = acc_ff;
      use_in       = use_ff;
      active_in    = active_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      q_take  = 1'b0;
      pos_clr = 1'b0;
      pos_inc = 1'b0;
      play_do = 1'b0;
      wr_do   = 1'b0;
      rd_pos  = pos_ff[vi];
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               out_in = '0;
               out_in.last_of_run = 1'b1;
               unique case (req_code_type'(q_item.req_type))
                  REQ_WRITE: begin
                     q_take = 1'b1;
                     wr_do = 1'b1;
                     out_valid_in = 1'b1;
                     out_in.result_kind = KIND_WRITTEN;
                  end
                  REQ_PLAY: begin
                     q_take = 1'b1;
                     out_valid_in = 1'b1;
                     if (free_any) begin
                        play_do = 1'b1;
                        active_in[free_idx] = 1'b1;
                        out_in.result_kind = KIND_STARTED;
                        out_in.voice_id = 3'(free_idx);
                     end else begin
                        out_in.result_kind = KIND_NOFREE;
                     end
                  end
                  REQ_STOP: begin
                     q_take = 1'b1;
                     if ({29'd0, q_item.voice_index} < 32'(VOICES) && active_ff[stop_idx]) begin
                        active_in[stop_idx] = 1'b0;
                        if (notify_ff[stop_idx]) begin
                           out_valid_in = 1'b1;
                           out_in.result_kind = KIND_STOPPED;
                           out_in.voice_id = q_item.voice_index;
                        end
                     end
                  end
                  REQ_MIX: begin
                     vcnt_in = '0;
                     acc_in = '0;
                     state_in = ST_MIX_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_MIX_RD: begin
            // one voice per visit: decide its end case, issue store read
            if (vcnt_ff == (VW+1)'(VOICES)) begin
               state_in = ST_DONE;
            end else if (!active_ff[vi]) begin
               vcnt_in = vcnt_ff + 1'b1;
            end else if (out_free) begin
               use_in = 1'b1;
               if (pos_ff[vi] >= span_ff[vi]) begin
                  if (repeat_ff[vi] && span_ff[vi] != 15'd0) begin
                     rd_pos = '0;
                     pos_clr = 1'b1;
                     if (notify_ff[vi]) begin
                        out_valid_in = 1'b1;
                        out_in = '0;
                        out_in.result_kind = KIND_REPEATED;
                        out_in.voice_id = 3'(vi);
                     end
                  end else begin
                     use_in = 1'b0;
                     active_in[vi] = 1'b0;
                     if (notify_ff[vi]) begin
                        out_valid_in = 1'b1;
                        out_in = '0;
                        out_in.result_kind = KIND_FINISHED;
                        out_in.voice_id = 3'(vi);
                     end
                  end
               end
               state_in = ST_MIX_ACC;
            end
         end
         ST_MIX_ACC: begin
            if (use_ff) begin
               acc_in = acc_ff + 35'(prod);
               pos_inc = 1'b1;
            end
            vcnt_in = vcnt_ff + 1'b1;
            state_in = ST_MIX_RD;
         end
         ST_DONE: begin
            if (out_free) begin
               q_take = 1'b1;
               out_valid_in = 1'b1;
               out_in = '0;
               out_in.result_kind = KIND_MIX;
               out_in.mixed_sample = sat;
               out_in.last_of_run = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rd_addr = AW'({1'b0, base_ff[vi]} + rd_pos);
      wr_addr = AW'(q_item.store_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         active_ff    <= '0;
         repeat_ff    <= '0;
         notify_ff    <= '0;
         for (int i = 0; i < VOICES; i++) begin
            gain_ff[i] <= '0;
            base_ff[i] <= '0;
            span_ff[i] <= '0;
            pos_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         active_ff    <= active_in;
         if (play_do) begin
            repeat_ff[free_idx] <= q_item.repeat_flag;
            notify_ff[free_idx] <= q_item.notify_flag;
            gain_ff[free_idx]   <= q_item.volume;
            base_ff[free_idx]   <= q_item.sound_start;
            span_ff[free_idx]   <= q_item.sound_length;
            pos_ff[free_idx]    <= '0;
         end
         if (pos_clr) pos_ff[vi] <= '0;
         if (pos_inc) pos_ff[vi] <= pos_ff[vi] + 15'd1;
      end
   end

   always_ff @(posedge clock) begin
      vcnt_ff <= vcnt_in;
      acc_ff  <= acc_in;
      use_ff  <= use_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_do) store_mem[wr_addr] <= q_item.store_value;
      rd_data_ff <= store_mem[rd_addr];
   end
endmodule
`default_nettype wire

[design/sample_voice_mixer.sv]
// ----------------------------------------------------------------------------
// sample_voice_mixer: eight-voice PCM sample playback mixer
// Request queue in front of a voice engine with a sample store.
// ----------------------------------------------------------------------------
// An accepted item is registered in the request queue before the engine sees
// it. Write, play and stop requests are each taken in the idle state, and any
// result they give shows in the output register the cycle after. A mix request
// visits each voice in ST_MIX_RD, which skips a free voice and issues the
// store read of an active one, then ST_MIX_ACC, which multiplies and
// accumulates; ST_DONE emits the mixed sample. A result waiting in the output
// register stalls the engine. Events come in voice order, the mixed sample last.
`default_nettype none
module sample_voice_mixer #(
   parameter int VOICES       = svm_pkg::VOICES_DEF,
   parameter int SAMPLE_WORDS = svm_pkg::SAMPLE_WORDS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   svm_if.sink      req_chan,
   svm_if.source    rsp_chan
);
   import svm_pkg::*;

   logic         q_valid, q_take;
   req_type_type q_item;

   svm_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_chan.valid), .in_ready(req_chan.ready), .in_item(req_chan.payload),
      .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   svm_back #(.VOICES(VOICES), .SAMPLE_WORDS(SAMPLE_WORDS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
      .out_valid(rsp_chan.valid), .out_ready(rsp_chan.ready), .out_item(rsp_chan.payload)
   );
endmodule
`default_nettype wire

[bench/mixer_checker.sv]
// ----------------------------------------------------------------------------
// mixer_checker: result predictor and comparator for the voice mixer
// Watches accepted requests, predicts the results they cause and compares
// each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module mixer_checker
   import svm_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire req_type_type req_item,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_type_type rsp_item,
   output int               fail_count,
   output int               pending_count
);

   logic              active_q [8];
   logic              loop_q [8];
   logic              notify_q [8];
   logic [15:0]       gain_q [8];
   logic [13:0]       base_q [8];
   logic [14:0]       span_q [8];
   logic [14:0]       pos_q [8];
   logic signed [15:0] store_q [16384];
   rsp_type_type      expected_results [$];

   assign pending_count = expected_results.size();

   function automatic rsp_type_type mk(kind_type k, logic [2:0] v, logic signed [15:0] s);
      rsp_type_type r;
      r.result_kind  = k;
      r.voice_id     = v;
      r.mixed_sample = s;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   task automatic predict_request(input req_type_type rq);
      rsp_type_type out [$];
      logic signed [47:0] acc;
      logic signed [47:0] q;
      logic [13:0] addr;
      bit placed;
      acc = '0;
      placed = 0;
      case (req_code_type'(rq.req_type))
         REQ_WRITE: begin
            store_q[rq.store_addr] = rq.store_value;
            out.push_back(mk(KIND_WRITTEN, 3'd0, 16'sd0));
         end
         REQ_PLAY: begin
            for (int v = 0; v < 8; v++) begin
               if (!placed && !active_q[v]) begin
                  active_q[v] = 1'b1;
                  base_q[v]   = rq.sound_start;
                  span_q[v]   = rq.sound_length;
                  loop_q[v]   = rq.repeat_flag;
                  gain_q[v]   = rq.volume;
                  notify_q[v] = rq.notify_flag;
                  pos_q[v]    = '0;
                  out.push_back(mk(KIND_STARTED, 3'(v), 16'sd0));
                  placed = 1;
               end
            end
            if (!placed) out.push_back(mk(KIND_NOFREE, 3'd0, 16'sd0));
         end
         REQ_STOP: begin
            if (active_q[rq.voice_index]) begin
               if (notify_q[rq.voice_index])
                  out.push_back(mk(KIND_STOPPED, rq.voice_index, 16'sd0));
               active_q[rq.voice_index] = 1'b0;
            end
         end
         default: begin
            for (int v = 0; v < 8; v++) begin
               if (active_q[v]) begin
                  if (pos_q[v] >= span_q[v]) begin
                     if (loop_q[v] && span_q[v] != 0) begin
                        if (notify_q[v]) out.push_back(mk(KIND_REPEATED, 3'(v), 16'sd0));
                        pos_q[v] = '0;
                     end else begin
                        if (notify_q[v]) out.push_back(mk(KIND_FINISHED, 3'(v), 16'sd0));
                        active_q[v] = 1'b0;
                     end
                  end
                  if (active_q[v]) begin
                     addr = base_q[v] + 14'(pos_q[v]);
                     acc += 48'(store_q[addr]) * $signed({32'd0, gain_q[v]});
                     pos_q[v] = pos_q[v] + 15'd1;
                  end
               end
            end
            q = (acc + 48'sd8192) >>> 14;
            if (q > 48'sd32767) q = 48'sd32767;
            if (q < -48'sd32768) q = -48'sd32768;
            out.push_back(mk(KIND_MIX, 3'd0, q[15:0]));
         end
      endcase
      if (out.size() > 0) out[out.size() - 1].last_of_run = 1'b1;
      foreach (out[i]) expected_results.push_back(out[i]);
   endtask

   always @(posedge clock) begin
      rsp_type_type exp_r;
      if (reset) begin
         for (int v = 0; v < 8; v++) begin
            active_q[v] = 0; loop_q[v] = 0; notify_q[v] = 0;
            gain_q[v] = 0; base_q[v] = 0; span_q[v] = 0; pos_q[v] = 0;
         end
         expected_results.delete();
         fail_count <= 0;
      end else begin
         // results first: a request accepted this edge cannot answer at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result %p", rsp_item);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_item !== exp_r) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p", exp_r, rsp_item);
               end
            end
         end
         if (req_valid && req_ready) predict_request(req_item);
      end
   end

endmodule
`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top of the voice mixer bench
// Drives directed then random requests under three idling profiles, with a
// checker alongside the block; reports a single verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import svm_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 32;
   int   recv_idle_pct = 54;
   int   stall_cycles = 0;
   int   fail_count;
   int   pending_count;
   bit   written [16384];
   logic [13:0] written_list [$];

   svm_if #(.PAYLOAD_TYPE(req_type_type)) req_chan (clock);
   svm_if #(.PAYLOAD_TYPE(rsp_type_type)) rsp_chan (clock);

   sample_voice_mixer dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   mixer_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready), .req_item(req_chan.payload),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready), .rsp_item(rsp_chan.payload),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles with nothing accepted
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // valid stays high across back-to-back items; it drops only while idling or when the bus is released
   task automatic send(input req_type_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= rq;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (rq.req_type == REQ_WRITE && !written[rq.store_addr]) begin
         written[rq.store_addr] = 1;
         written_list.push_back(rq.store_addr);
      end
   endtask

   task automatic release_bus();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type_type rand_noise();
      req_type_type rq;
      rq = req_type_type'($bits(req_type_type)'({$urandom, $urandom, $urandom}));
      return rq;
   endfunction

   function automatic req_type_type mk_write(logic [13:0] a, logic [15:0] d);
      req_type_type rq;
      rq = rand_noise();
      rq.req_type = REQ_WRITE; rq.store_addr = a; rq.store_value = d;
      return rq;
   endfunction

   function automatic req_type_type mk_play(logic [13:0] s, logic [14:0] n, bit rp,
                                            logic [15:0] g, bit nt);
      req_type_type rq;
      rq = rand_noise();
      rq.req_type = REQ_PLAY; rq.sound_start = s; rq.sound_length = n;
      rq.repeat_flag = rp; rq.volume = g; rq.notify_flag = nt;
      return rq;
   endfunction

   function automatic req_type_type mk_op(req_code_type op, logic [2:0] v);
      req_type_type rq;
      rq = rand_noise();
      rq.req_type = op; rq.voice_index = v;
      return rq;
   endfunction

   // plays a sound over a fully written region so no unwritten word is read
   task automatic rand_play();
      logic [13:0] s;
      int n;
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      s = 14'($urandom);
      for (int i = 0; i < n; i++) send(mk_write(s + 14'(i), 16'($urandom)));
      send(mk_play(s, 15'(n), 1'($urandom_range(1)), 16'($urandom),
                   $urandom_range(3) != 0));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, wrap, saturation, zero length, no free voice
      send(mk_write(14'h3FFF, 16'h7FFF));
      send(mk_write(14'h0000, 16'h8000));
      send(mk_write(14'h0001, 16'h7FFF));
      send(mk_play(14'h3FFF, 15'd3, 1'b1, 16'hFFFF, 1'b1));
      send(mk_play(14'h3FFF, 15'd3, 1'b0, 16'hFFFF, 1'b1));
      send(mk_play(14'h0000, 15'd0, 1'b1, 16'h4000, 1'b1));
      send(mk_play(14'h0000, 15'd0, 1'b0, 16'h0000, 1'b0));
      for (int i = 0; i < 5; i++) send(mk_op(REQ_MIX, 3'd0));
      for (int i = 0; i < 9; i++) send(mk_play(14'h0000, 15'h7FFF, 1'b0, 16'hFFFF, i[0]));
      send(mk_op(REQ_MIX, 3'd0));
      for (int v = 0; v < 8; v++) send(mk_op(REQ_STOP, 3'(v)));
      send(mk_op(REQ_STOP, 3'd7));
      send(mk_write(14'h0000, 16'h0000));
      send(mk_write(14'h0001, 16'h0000));
      send(mk_play(14'h3FFF, 15'd2, 1'b0, 16'hFFFF, 1'b1));
      send(mk_op(REQ_MIX, 3'd0));
      send(mk_op(REQ_MIX, 3'd0));

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 54 : 0;
         recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 32 : 0;
         for (int k = 0; k < 30; k++) begin
            case ($urandom_range(9))
               0, 1, 2: rand_play();
               3:       send(mk_op(REQ_STOP, 3'($urandom)));
               4:       send(mk_write(written_list[$urandom_range(written_list.size() - 1)],
                                      16'($urandom)));
               default: send(mk_op(REQ_MIX, 3'd0));
            endcase
         end
         // drain before switching idling profile
         release_bus();
         while (pending_count != 0) @(posedge clock);
      end

      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
design/svm_pkg.sv
design/svm_if.sv
design/svm_front.sv
design/svm_back.sv
design/sample_voice_mixer.sv
bench/mixer_checker.sv
bench/testbench.sv
